// ----- src/prrs_pkg.sv -----
// Shared definitions for the priority round-robin scheduler.
// Field widths, opcodes, status codes and register map constants.
// No dependencies.
`default_nettype none

package prrs_pkg;

    // Default sizes of the task table and of the level set
    localparam int NUM_TASKS_DEF  = 32;
    localparam int NUM_LEVELS_DEF = 8;

    // Fixed port field widths
    localparam int OPCODE_W  = 3;
    localparam int TASK_ID_W = 5;
    localparam int PRIO_W    = 3;
    localparam int WAIT_W    = 4;
    localparam int STATUS_W  = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register index, taken from paddr[2]
    localparam logic REG_SCHEDULE_LOCK = 1'b0;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_READY_TAIL = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_READY_HEAD = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_HOLD       = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_BLOCK      = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SCHEDULE   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_LOCKED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE   = 2'd2;

endpackage

`default_nettype wire

// ----- src/prrs_cfg.sv -----
// APB-style register block for the scheduler: holds the schedule lock bit.
// Depends on prrs_pkg for the register map and port widths.
`default_nettype none

module prrs_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [prrs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [prrs_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [prrs_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output logic                                  schedule_lock
);

    logic lock_reg;
    logic wr_en;
    logic sel_lock;

    // Register decode; low address bits ignored
    assign sel_lock = (paddr[2] == prrs_pkg::REG_SCHEDULE_LOCK);
    assign wr_en    = psel & penable & pwrite;
    assign pready   = 1'b1;

    // Lock register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_reg <= 1'b0;
        end
        else if (wr_en && sel_lock)
        begin
            lock_reg <= pwdata[0];
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        if (sel_lock)
        begin
            prdata[0] = lock_reg;
        end
    end

    assign schedule_lock = lock_reg;

endmodule

`default_nettype wire

// ----- src/priority_round_robin_scheduler_unit.sv -----
// Top level of the priority round-robin scheduler: run queues, sequencer, results.
// Depends on prrs_pkg and prrs_cfg.
//
// One FIFO run queue per priority level, kept as a doubly linked list over task
// slots in RAM. A command is taken when start is high and busy is low; busy
// stays high until the command finishes, and the result word is then shown for
// exactly one cycle with done high, in the first cycle that busy is low again.
// The receiver cannot stall; results must be taken as they come. The next
// command may be issued in the cycle done is high. Commands that need no queue
// work (locked schedule, hold or block of a task not in a queue, opcodes 5 to 7,
// task slots at or beyond NUM_TASKS) keep busy low and show done in the cycle
// after they are taken. A ready command unlinks an already queued task first
// (ST_DT_LINK, ST_DT_Q; each step waits on a registered RAM read), then links it
// in ST_AT_START, adding ST_AT_Q for a non-empty level. Hold and block of a queued
// task only unlink it. Schedule scans one level per cycle from the top, down to the
// bottom level when nothing is ready, and rotates the picked task to the tail
// of its queue through the unlink and link states when it is not alone there.
`default_nettype none

module priority_round_robin_scheduler_unit #(
    parameter int NUM_TASKS  = prrs_pkg::NUM_TASKS_DEF,
    parameter int NUM_LEVELS = prrs_pkg::NUM_LEVELS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // command channel
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [prrs_pkg::OPCODE_W-1:0]    opcode,
    input  wire logic [prrs_pkg::TASK_ID_W-1:0]   task_id,
    input  wire logic [prrs_pkg::PRIO_W-1:0]      priority_req,
    input  wire logic [prrs_pkg::WAIT_W-1:0]      wait_code,
    // result channel
    output logic                                  done,
    output logic      [prrs_pkg::TASK_ID_W-1:0]   picked_task,
    output logic      [prrs_pkg::PRIO_W-1:0]      picked_priority,
    output logic      [prrs_pkg::STATUS_W-1:0]    status,
    // configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [prrs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [prrs_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [prrs_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    localparam int TASK_W = $clog2(NUM_TASKS);
    localparam int LVL_W  = $clog2(NUM_LEVELS);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SCAN     = 7'b0000010,
        ST_SC_HEAD  = 7'b0000100,
        ST_DT_LINK  = 7'b0001000,
        ST_DT_Q     = 7'b0010000,
        ST_AT_START = 7'b0100000,
        ST_AT_Q     = 7'b1000000
    } state_t;

    // Configuration
    logic schedule_lock;

    prrs_cfg u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .schedule_lock (schedule_lock)
    );

    // Control state
    state_t                state_reg, state_next;
    logic                  done_reg, done_next;
    logic [NUM_LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [NUM_TASKS-1:0]  ready_reg, ready_next;

    // Working registers
    logic [LVL_W-1:0]  scan_lvl_reg, scan_lvl_next;
    logic [TASK_W-1:0] t_reg, t_next;
    logic [LVL_W-1:0]  lv_reg, lv_next;
    logic              front_reg, front_next;
    logic              att_reg, att_next;
    logic [TASK_W-1:0] p_reg, p_next;
    logic [TASK_W-1:0] n_reg, n_next;
    logic [LVL_W-1:0]  dl_reg, dl_next;

    // Result word
    logic [prrs_pkg::TASK_ID_W-1:0] res_task_reg, res_task_next;
    logic [prrs_pkg::PRIO_W-1:0]    res_prio_reg, res_prio_next;
    logic [prrs_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;

    // Link RAMs, indexed by task slot
    logic [TASK_W-1:0] next_mem  [NUM_TASKS];
    logic [TASK_W-1:0] prev_mem  [NUM_TASKS];
    logic [LVL_W-1:0]  level_mem [NUM_TASKS];
    // Queue end RAMs, indexed by level
    logic [TASK_W-1:0] head_mem  [NUM_LEVELS];
    logic [TASK_W-1:0] tail_mem  [NUM_LEVELS];

    logic              next_we,  prev_we,  level_we,  head_we,  tail_we;
    logic [TASK_W-1:0] next_waddr, prev_waddr;
    logic [TASK_W-1:0] next_wdata, prev_wdata;
    logic [LVL_W-1:0]  head_waddr, tail_waddr;
    logic [TASK_W-1:0] head_wdata, tail_wdata;
    logic [TASK_W-1:0] link_raddr;
    logic [LVL_W-1:0]  queue_raddr;
    logic [TASK_W-1:0] next_q, prev_q;
    logic [LVL_W-1:0]  level_q;
    logic [TASK_W-1:0] head_q, tail_q;

    // Decoded command fields
    logic              t_ok;
    logic [TASK_W-1:0] t_in;
    logic [LVL_W-1:0]  lv_in;
    logic              at_head, at_tail;

    assign t_ok    = (int'(task_id) < NUM_TASKS);
    assign t_in    = TASK_W'(task_id);
    assign lv_in   = (int'(priority_req) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                        : LVL_W'(priority_req);
    assign at_head = (head_q == t_reg);
    assign at_tail = (tail_q == t_reg);

    // RAMs with registered reads
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (level_we)
        begin
            level_mem[t_reg] <= lv_reg;
        end
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (tail_we)
        begin
            tail_mem[tail_waddr] <= tail_wdata;
        end
        next_q  <= next_mem[link_raddr];
        prev_q  <= prev_mem[link_raddr];
        level_q <= level_mem[link_raddr];
        head_q  <= head_mem[queue_raddr];
        tail_q  <= tail_mem[queue_raddr];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        nonempty_next   = nonempty_reg;
        ready_next      = ready_reg;
        scan_lvl_next   = scan_lvl_reg;
        t_next          = t_reg;
        lv_next         = lv_reg;
        front_next      = front_reg;
        att_next        = att_reg;
        p_next          = p_reg;
        n_next          = n_reg;
        dl_next         = dl_reg;
        res_task_next   = res_task_reg;
        res_prio_next   = res_prio_reg;
        res_status_next = res_status_reg;

        next_we    = 1'b0;
        prev_we    = 1'b0;
        level_we   = 1'b0;
        head_we    = 1'b0;
        tail_we    = 1'b0;
        next_waddr = t_reg;
        next_wdata = t_reg;
        prev_waddr = t_reg;
        prev_wdata = t_reg;
        head_waddr = lv_reg;
        head_wdata = t_reg;
        tail_waddr = lv_reg;
        tail_wdata = t_reg;
        link_raddr = t_reg;
        queue_raddr = lv_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                link_raddr = t_in;
                if (start)
                begin
                    t_next          = t_in;
                    lv_next         = lv_in;
                    front_next      = (opcode == prrs_pkg::OP_READY_HEAD);
                    att_next        = (opcode == prrs_pkg::OP_READY_TAIL) ||
                                      (opcode == prrs_pkg::OP_READY_HEAD);
                    res_task_next   = '0;
                    res_prio_next   = '0;
                    res_status_next = prrs_pkg::STAT_DONE;
                    unique case (opcode) inside
                        prrs_pkg::OP_SCHEDULE:
                        begin
                            if (schedule_lock)
                            begin
                                res_status_next = prrs_pkg::STAT_LOCKED;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                scan_lvl_next = LVL_W'(NUM_LEVELS - 1);
                                state_next    = ST_SCAN;
                            end
                        end
                        prrs_pkg::OP_READY_TAIL, prrs_pkg::OP_READY_HEAD,
                        prrs_pkg::OP_HOLD, prrs_pkg::OP_BLOCK:
                        begin
                            if (!t_ok)
                            begin
                                done_next = 1'b1;
                            end
                            else if (ready_reg[t_in])
                            begin
                                state_next = ST_DT_LINK;
                            end
                            else if (att_next)
                            begin
                                state_next = ST_AT_START;
                            end
                            else
                            begin
                                // hold or block of a task not in a queue
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // Walk levels from the top, one per cycle
            ST_SCAN:
            begin
                queue_raddr = scan_lvl_reg;
                if (nonempty_reg[scan_lvl_reg])
                begin
                    state_next = ST_SC_HEAD;
                end
                else if (scan_lvl_reg == '0)
                begin
                    res_status_next = prrs_pkg::STAT_NONE;
                    done_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    scan_lvl_next = scan_lvl_reg - 1'b1;
                end
            end

            // Report the head; rotate it when the queue holds more than one
            ST_SC_HEAD:
            begin
                link_raddr      = head_q;
                res_task_next   = prrs_pkg::TASK_ID_W'(head_q);
                res_prio_next   = prrs_pkg::PRIO_W'(scan_lvl_reg);
                res_status_next = prrs_pkg::STAT_DONE;
                if (tail_q != head_q)
                begin
                    t_next     = head_q;
                    lv_next    = scan_lvl_reg;
                    front_next = 1'b0;
                    att_next   = 1'b1;
                    state_next = ST_DT_LINK;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // Unlink: neighbors and level of the task are in hand
            ST_DT_LINK:
            begin
                queue_raddr = level_q;
                p_next      = prev_q;
                n_next      = next_q;
                dl_next     = level_q;
                state_next  = ST_DT_Q;
            end

            // Unlink: patch the queue ends or the neighbors
            ST_DT_Q:
            begin
                head_waddr = dl_reg;
                tail_waddr = dl_reg;
                if (at_head && at_tail)
                begin
                    nonempty_next[dl_reg] = 1'b0;
                end
                else if (at_head)
                begin
                    head_we    = 1'b1;
                    head_wdata = n_reg;
                end
                else if (at_tail)
                begin
                    tail_we    = 1'b1;
                    tail_wdata = p_reg;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = p_reg;
                    next_wdata = n_reg;
                    prev_we    = 1'b1;
                    prev_waddr = n_reg;
                    prev_wdata = p_reg;
                end
                if (att_reg)
                begin
                    state_next = ST_AT_START;
                end
                else
                begin
                    ready_next[t_reg] = 1'b0;
                    done_next         = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            // Link: empty level takes the task directly, else go on to ST_AT_Q
            ST_AT_START:
            begin
                level_we = 1'b1;
                if (!nonempty_reg[lv_reg])
                begin
                    head_we               = 1'b1;
                    tail_we               = 1'b1;
                    nonempty_next[lv_reg] = 1'b1;
                    ready_next[t_reg]     = 1'b1;
                    done_next             = 1'b1;
                    state_next            = ST_IDLE;
                end
                else
                begin
                    state_next = ST_AT_Q;
                end
            end

            // Link at head or tail of a non-empty level
            ST_AT_Q:
            begin
                if (front_reg)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = head_q;
                    prev_wdata = t_reg;
                    next_we    = 1'b1;
                    next_waddr = t_reg;
                    next_wdata = head_q;
                    head_we    = 1'b1;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = tail_q;
                    next_wdata = t_reg;
                    prev_we    = 1'b1;
                    prev_waddr = t_reg;
                    prev_wdata = tail_q;
                    tail_we    = 1'b1;
                end
                ready_next[t_reg] = 1'b1;
                done_next         = 1'b1;
                state_next        = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            nonempty_reg <= '0;
            ready_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            nonempty_reg <= nonempty_next;
            ready_reg    <= ready_next;
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        scan_lvl_reg   <= scan_lvl_next;
        t_reg          <= t_next;
        lv_reg         <= lv_next;
        front_reg      <= front_next;
        att_reg        <= att_next;
        p_reg          <= p_next;
        n_reg          <= n_next;
        dl_reg         <= dl_next;
        res_task_reg   <= res_task_next;
        res_prio_reg   <= res_prio_next;
        res_status_reg <= res_status_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign picked_task     = res_task_reg;
    assign picked_priority = res_prio_reg;
    assign status          = res_status_reg;

endmodule

`default_nettype wire

// ----- verif/priority_round_robin_scheduler_unit_test.sv -----
// Testbench for priority_round_robin_scheduler_unit: a lock register check, a directed run,
// then random ready/hold/block/schedule traffic, checked word by word against a run-queue predictor.
// Depends on prrs_pkg and the scheduler RTL only.
`timescale 1ns / 1ps

module priority_round_robin_scheduler_unit_test;

    localparam int TASKS  = prrs_pkg::NUM_TASKS_DEF;
    localparam int LEVELS = prrs_pkg::NUM_LEVELS_DEF;

    // Task conditions kept by the predictor
    localparam logic [4:0] COND_IDLE  = 5'd0;
    localparam logic [4:0] COND_READY = 5'd1;
    localparam logic [4:0] COND_HELD  = 5'd2;
    localparam logic [4:0] COND_BLOCK = 5'd16;

    typedef struct packed {
        logic [prrs_pkg::TASK_ID_W-1:0] picked_task;
        logic [prrs_pkg::PRIO_W-1:0]    picked_priority;
        logic [prrs_pkg::STATUS_W-1:0]  status;
    } pick_t;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic [prrs_pkg::OPCODE_W-1:0]    opcode;
    logic [prrs_pkg::TASK_ID_W-1:0]   task_id;
    logic [prrs_pkg::PRIO_W-1:0]      priority_req;
    logic [prrs_pkg::WAIT_W-1:0]      wait_code;
    logic                             done;
    logic [prrs_pkg::TASK_ID_W-1:0]   picked_task;
    logic [prrs_pkg::PRIO_W-1:0]      picked_priority;
    logic [prrs_pkg::STATUS_W-1:0]    status;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [prrs_pkg::CFG_ADDR_W-1:0]  paddr;
    logic [prrs_pkg::CFG_DATA_W-1:0]  pwdata;
    logic [prrs_pkg::CFG_DATA_W-1:0]  prdata;
    logic                             pready;

    priority_round_robin_scheduler_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .opcode          (opcode),
        .task_id         (task_id),
        .priority_req    (priority_req),
        .wait_code       (wait_code),
        .done            (done),
        .picked_task     (picked_task),
        .picked_priority (picked_priority),
        .status          (status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Predictor copy of the run queues
    logic [prrs_pkg::TASK_ID_W-1:0] q_head [LEVELS];
    logic [prrs_pkg::TASK_ID_W-1:0] q_tail [LEVELS];
    logic                           q_live [LEVELS];
    logic [prrs_pkg::TASK_ID_W-1:0] link_next [TASKS];
    logic [prrs_pkg::TASK_ID_W-1:0] link_prev [TASKS];
    logic [prrs_pkg::PRIO_W-1:0]    task_lvl [TASKS];
    logic [4:0]                     task_cond [TASKS];
    logic                           lock_shadow;

    pick_t pending_picks [$];
    int    fail_count;
    int    words_sent;
    int    words_checked;
    int    picks_seen;
    int    locked_seen;
    int    empty_seen;
    bit    idle_on;

    // Take a task out of its level's list
    function automatic void unlink_task(input logic [prrs_pkg::TASK_ID_W-1:0] t);
        logic [prrs_pkg::PRIO_W-1:0]    lv;
        logic [prrs_pkg::TASK_ID_W-1:0] p;
        logic [prrs_pkg::TASK_ID_W-1:0] n;
        lv = task_lvl[t];
        p  = link_prev[t];
        n  = link_next[t];
        if (q_head[lv] == t && q_tail[lv] == t)
            q_live[lv] = 1'b0;
        else if (q_head[lv] == t)
            q_head[lv] = n;
        else if (q_tail[lv] == t)
            q_tail[lv] = p;
        else
        begin
            link_next[p] = n;
            link_prev[n] = p;
        end
    endfunction

    // Put a task at the head or tail of a level's list
    function automatic void link_task(input logic [prrs_pkg::TASK_ID_W-1:0] t,
                                      input logic [prrs_pkg::PRIO_W-1:0] lv,
                                      input bit front);
        logic [prrs_pkg::TASK_ID_W-1:0] h;
        logic [prrs_pkg::TASK_ID_W-1:0] e;
        h = q_head[lv];
        e = q_tail[lv];
        task_lvl[t] = lv;
        if (!q_live[lv])
        begin
            q_head[lv] = t;
            q_tail[lv] = t;
            q_live[lv] = 1'b1;
        end
        else if (front)
        begin
            link_prev[h] = t;
            link_next[t] = h;
            q_head[lv]   = t;
        end
        else
        begin
            link_next[e] = t;
            link_prev[t] = e;
            q_tail[lv]   = t;
        end
    endfunction

    // Apply one command to the predicted queues and return the expected word
    function automatic pick_t run_queue_step(input logic [prrs_pkg::OPCODE_W-1:0] op,
                                             input logic [prrs_pkg::TASK_ID_W-1:0] t,
                                             input logic [prrs_pkg::PRIO_W-1:0] lv,
                                             input logic [prrs_pkg::WAIT_W-1:0] code);
        pick_t                          r;
        bit                             found;
        logic [prrs_pkg::TASK_ID_W-1:0] h;
        r     = '0;
        found = 1'b0;
        if (op == prrs_pkg::OP_SCHEDULE)
        begin
            if (lock_shadow)
                r.status = prrs_pkg::STAT_LOCKED;
            else
            begin
                r.status = prrs_pkg::STAT_NONE;
                for (int l = LEVELS - 1; l >= 0; l--)
                begin
                    if (!found && q_live[l])
                    begin
                        found             = 1'b1;
                        h                 = q_head[l];
                        r.picked_task     = h;
                        r.picked_priority = prrs_pkg::PRIO_W'(l);
                        r.status          = prrs_pkg::STAT_DONE;
                        // rotate to the tail unless it is alone
                        if (q_tail[l] != h)
                        begin
                            unlink_task(h);
                            link_task(h, prrs_pkg::PRIO_W'(l), 1'b0);
                        end
                    end
                end
            end
        end
        else if (op <= prrs_pkg::OP_BLOCK)
        begin
            if (task_cond[t] == COND_READY)
                unlink_task(t);
            if (op == prrs_pkg::OP_READY_TAIL || op == prrs_pkg::OP_READY_HEAD)
            begin
                link_task(t, lv, op == prrs_pkg::OP_READY_HEAD);
                task_cond[t] = COND_READY;
            end
            else if (op == prrs_pkg::OP_HOLD)
                task_cond[t] = COND_HELD;
            else
                task_cond[t] = COND_BLOCK | 5'(code);
        end
        return r;
    endfunction

    // Send one command word, honoring a random gap, and record its expected result
    task automatic send_cmd(input logic [prrs_pkg::OPCODE_W-1:0] op,
                            input logic [prrs_pkg::TASK_ID_W-1:0] tid,
                            input logic [prrs_pkg::PRIO_W-1:0] lv,
                            input logic [prrs_pkg::WAIT_W-1:0] code);
        int unsigned gap;
        pick_t       want_word;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode       = op;
        task_id      = tid;
        priority_req = lv;
        wait_code    = code;
        start        = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        want_word     = run_queue_step(op, tid, lv, code);
        pending_picks = {pending_picks, want_word};
        words_sent++;
        @(negedge clk);
    endtask

    // Hold off until every outstanding result word has come back
    task automatic drain_results();
        start = 1'b0;
        while (pending_picks.size() != 0)
            @(negedge clk);
    endtask

    // Write the lock register, then read it back
    task automatic write_lock(input logic val);
        logic [prrs_pkg::CFG_DATA_W-1:0] readback;
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {prrs_pkg::REG_SCHEDULE_LOCK, 2'b00};
        pwdata  = $urandom();
        pwdata[0] = val;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        lock_shadow = val;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (readback !== prrs_pkg::CFG_DATA_W'(lock_shadow))
        begin
            $error("schedule_lock readback: expected %0h, actual %0h", lock_shadow, readback);
            fail_count++;
        end
    endtask

    // A pick is any done word that names a task or a level
    function automatic bit opcode_was_sched(input pick_t w);
        return w.picked_task != '0 || w.picked_priority != '0;
    endfunction

    // Result checker
    always @(posedge clk)
    begin : check_results
        pick_t want;
        if (rst_n && done)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("result word with nothing expected: task %0d prio %0d status %0d",
                       picked_task, picked_priority, status);
                fail_count++;
            end
            else
            begin
                want = pending_picks.pop_front();
                words_checked++;
                if (picked_task !== want.picked_task)
                begin
                    $error("picked_task: expected %0d, actual %0d", want.picked_task, picked_task);
                    fail_count++;
                end
                if (picked_priority !== want.picked_priority)
                begin
                    $error("picked_priority: expected %0d, actual %0d",
                           want.picked_priority, picked_priority);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    fail_count++;
                end
                if (want.status == prrs_pkg::STAT_DONE && opcode_was_sched(want))
                    picks_seen++;
                if (want.status == prrs_pkg::STAT_LOCKED)
                    locked_seen++;
                if (want.status == prrs_pkg::STAT_NONE)
                    empty_seen++;
            end
        end
    end

    // Lock register write and readback right after reset
    task automatic test_register_access();
        write_lock(1'b1);
        write_lock(1'b0);
    endtask

    // Corner cases: empty queue, lone task, rotation, relinking, hold/block, bad opcodes, schedule lock
    task automatic test_directed();
        idle_on = 1'b1;
        send_cmd(prrs_pkg::OP_SCHEDULE, '0, '0, '0);
        send_cmd(prrs_pkg::OP_READY_TAIL, 5'd0, 3'd0, 4'd0);
        send_cmd(prrs_pkg::OP_SCHEDULE, 5'd31, 3'd7, 4'd15);
        send_cmd(prrs_pkg::OP_READY_HEAD, 5'd31, 3'd7, 4'd0);
        send_cmd(prrs_pkg::OP_READY_TAIL, 5'd5, 3'd7, 4'd0);
        send_cmd(prrs_pkg::OP_READY_TAIL, 5'd9, 3'd7, 4'd15);
        send_cmd(prrs_pkg::OP_SCHEDULE, '0, '0, '0);
        send_cmd(prrs_pkg::OP_SCHEDULE, '0, '0, '0);
        send_cmd(prrs_pkg::OP_READY_HEAD, 5'd9, 3'd7, 4'd0);
        send_cmd(prrs_pkg::OP_READY_TAIL, 5'd31, 3'd3, 4'd0);
        send_cmd(prrs_pkg::OP_HOLD, 5'd5, 3'd7, 4'd15);
        send_cmd(prrs_pkg::OP_BLOCK, 5'd9, 3'd0, 4'd15);
        send_cmd(prrs_pkg::OP_BLOCK, 5'd0, 3'd0, 4'd0);
        send_cmd(prrs_pkg::OP_SCHEDULE, '0, '0, '0);
        send_cmd(prrs_pkg::OP_SCHEDULE, '0, '0, '0);
        for (int u = prrs_pkg::OP_SCHEDULE + 1; u < 2 ** prrs_pkg::OPCODE_W; u++)
            send_cmd(prrs_pkg::OPCODE_W'(u), 5'd31, 3'd7, 4'd15);
        send_cmd(prrs_pkg::OP_HOLD, 5'd3, 3'd0, 4'd0);
        send_cmd(prrs_pkg::OP_READY_TAIL, 5'd31, 3'd7, 4'd0);
        send_cmd(prrs_pkg::OP_SCHEDULE, '0, '0, '0);
        // lock on: schedule refused, other commands still act
        drain_results();
        write_lock(1'b1);
        send_cmd(prrs_pkg::OP_SCHEDULE, '0, '0, '0);
        send_cmd(prrs_pkg::OP_READY_TAIL, 5'd1, 3'd6, 4'd0);
        send_cmd(prrs_pkg::OP_SCHEDULE, '0, '0, '0);
        drain_results();
        write_lock(1'b0);
        send_cmd(prrs_pkg::OP_SCHEDULE, '0, '0, '0);
        drain_results();
    endtask

    // Random command mix; mostly a small task pool so queues stay busy
    task automatic random_burst(input int count);
        int unsigned                    r;
        logic [prrs_pkg::OPCODE_W-1:0]  op;
        logic [prrs_pkg::TASK_ID_W-1:0] tid;
        logic [prrs_pkg::PRIO_W-1:0]    lv;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                idle_on = $urandom_range(0, 1);
            // sender waits for the block to go quiet once, halfway through the burst
            if (i == count / 2)
                drain_results();
            r = $urandom_range(0, 99);
            if (r < 30)
                op = prrs_pkg::OP_READY_TAIL;
            else if (r < 42)
                op = prrs_pkg::OP_READY_HEAD;
            else if (r < 52)
                op = prrs_pkg::OP_HOLD;
            else if (r < 62)
                op = prrs_pkg::OP_BLOCK;
            else if (r < 96)
                op = prrs_pkg::OP_SCHEDULE;
            else
                op = prrs_pkg::OPCODE_W'($urandom_range(prrs_pkg::OP_SCHEDULE + 1,
                                                        2 ** prrs_pkg::OPCODE_W - 1));
            tid = $urandom_range(0, 2) != 0
                ? prrs_pkg::TASK_ID_W'($urandom_range(0, 7))
                : prrs_pkg::TASK_ID_W'($urandom_range(0, TASKS - 1));
            lv  = $urandom_range(0, 1) != 0
                ? prrs_pkg::PRIO_W'($urandom_range(0, LEVELS - 1))
                : prrs_pkg::PRIO_W'($urandom_range(LEVELS - 2, LEVELS - 1));
            send_cmd(op, tid, lv,
                     prrs_pkg::WAIT_W'($urandom_range(0, 2 ** prrs_pkg::WAIT_W - 1)));
        end
        drain_results();
    endtask

    // Random traffic in phases, with the lock set between some of them
    task automatic test_random_traffic();
        random_burst(400);
        write_lock(1'b1);
        random_burst(100);
        write_lock(1'b0);
        random_burst(400);
        write_lock(1'b1);
        write_lock(1'b0);
        random_burst(350);
    endtask

    initial
    begin
        int waited;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = '0;
        task_id      = '0;
        priority_req = '0;
        wait_code    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        fail_count    = 0;
        words_sent    = 0;
        words_checked = 0;
        picks_seen    = 0;
        locked_seen   = 0;
        empty_seen    = 0;
        idle_on       = 1'b0;
        lock_shadow   = 1'b0;
        for (int l = 0; l < LEVELS; l++)
        begin
            q_head[l] = '0;
            q_tail[l] = '0;
            q_live[l] = 1'b0;
        end
        for (int t = 0; t < TASKS; t++)
        begin
            link_next[t] = '0;
            link_prev[t] = '0;
            task_lvl[t]  = '0;
            task_cond[t] = COND_IDLE;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_register_access();
        test_directed();
        test_random_traffic();

        // wind down
        start  = 1'b0;
        waited = 0;
        while (pending_picks.size() != 0 && waited < 5000)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_picks.size() != 0)
        begin
            $error("%0d result words never arrived", pending_picks.size());
            fail_count++;
        end
        repeat (20) @(posedge clk);

        $display("Ran %0d commands, checked %0d result words.", words_sent, words_checked);
        $display("Schedule outcomes: %0d tasks picked, %0d refused by lock, %0d with no task ready.",
                 picks_seen, locked_seen, empty_seen);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/prrs_pkg.sv
src/prrs_cfg.sv
src/priority_round_robin_scheduler_unit.sv
verif/priority_round_robin_scheduler_unit_test.sv
